// File: design/prs_pkg.sv
// shared types and constants of the row pixel sorter
package prs_pkg;

    localparam int MAX_ROW_WIDTH_DEF = 1024;
    localparam int ROW_WIDTH_RESET   = 640;
    localparam int CFG_W             = 11;
    localparam int KEY_BINS          = 256;
    localparam int KEY_W             = 8;
    localparam int PIX_W             = 24;

    typedef struct packed {
        logic             is_pixel;
        logic [KEY_W-1:0] red;
        logic [KEY_W-1:0] green;
        logic [KEY_W-1:0] blue;
    } item_t;

endpackage

// File: design/prs_front.sv
// input side: accepts items and queues them for the sort engine
module prs_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_pixel_valid,
    input  logic [7:0]        s_red,
    input  logic [7:0]        s_green,
    input  logic [7:0]        s_blue,
    output logic              q_valid,
    output prs_pkg::item_t    q_item,
    input  logic              q_pop
);

    prs_pkg::item_t slot_reg [2];
    logic [1:0]     cnt_reg, cnt_next;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic           push;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (push) begin
                // drain items only pull output, the flag tells the engine apart
                slot_reg[wr_ptr_reg] <= '{is_pixel: s_pixel_valid, red: s_red,
                                          green: s_green, blue: s_blue};
            end
        end
    end

endmodule

// File: design/prs_back.sv
// sort engine: emits sorted pixels, loads rows, counting sort per row
module prs_back #(
    parameter int MAX_ROW_WIDTH = prs_pkg::MAX_ROW_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [prs_pkg::CFG_W-1:0] row_width,
    input  logic                      q_valid,
    input  prs_pkg::item_t            q_item,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_red,
    output logic [7:0]                m_out_green,
    output logic [7:0]                m_out_blue,
    output logic                      m_row_end
);

    localparam int AW = $clog2(MAX_ROW_WIDTH);
    localparam int CW = $clog2(MAX_ROW_WIDTH + 1);
    localparam int PW = prs_pkg::PIX_W;
    localparam int KW = prs_pkg::KEY_W;
    localparam int NB = prs_pkg::KEY_BINS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EMIT, ST_STORE, ST_HINC, ST_PREFIX, ST_SC_RD, ST_SC_KEY, ST_SC_WR
    } state_t;

    // memories
    logic [PW-1:0] load_mem [MAX_ROW_WIDTH];
    logic [PW-1:0] sort_mem [MAX_ROW_WIDTH];
    logic [CW-1:0] hist_mem [NB];
    logic [PW-1:0] load_rdata_reg, sort_rdata_reg;
    logic [CW-1:0] hist_rdata_reg;

    logic          load_we, sort_we, hist_we;
    logic [AW-1:0] load_waddr, load_raddr, sort_waddr, sort_raddr;
    logic [KW-1:0] hist_waddr, hist_raddr;
    logic [PW-1:0] load_wdata, sort_wdata;
    logic [CW-1:0] hist_wdata;

    state_t         state_reg, state_next;
    prs_pkg::item_t item_reg, item_next;
    logic [CW-1:0]  load_pos_reg, load_pos_next;
    logic [CW-1:0]  emit_pos_reg, emit_pos_next;
    logic [CW-1:0]  sorted_len_reg, sorted_len_next;
    logic           sorted_ready_reg, sorted_ready_next;
    logic [NB-1:0]  hist_vld_reg, hist_vld_next;
    logic [8:0]     k_reg, k_next;
    logic [CW-1:0]  acc_reg, acc_next;
    logic [CW-1:0]  scan_reg, scan_next;
    logic [PW-1:0]  px_reg, px_next;
    logic           out_valid_reg, out_valid_next;
    logic [PW-1:0]  out_px_reg, out_px_next;
    logic           out_end_reg, out_end_next;

    logic [CW-1:0]  eff_width;
    logic [CW-1:0]  pos_inc;
    logic [CW-1:0]  bin_cnt;
    logic [7:0]     prev_bin;
    logic           last;

    assign m_valid     = out_valid_reg;
    assign m_out_red   = out_px_reg[23:16];
    assign m_out_green = out_px_reg[15:8];
    assign m_out_blue  = out_px_reg[7:0];
    assign m_row_end   = out_end_reg;

    always_comb begin
        if (row_width == '0) begin
            eff_width = CW'(1);
        end else if (int'(row_width) > MAX_ROW_WIDTH) begin
            eff_width = CW'(MAX_ROW_WIDTH);
        end else begin
            eff_width = CW'(row_width);
        end
    end

    assign pos_inc  = load_pos_reg + CW'(1);
    assign last     = ({1'b0, emit_pos_reg} + {{CW{1'b0}}, 1'b1}) >= {1'b0, sorted_len_reg};
    assign prev_bin = 8'(k_reg - 9'd1);
    assign bin_cnt  = hist_vld_reg[prev_bin] ? hist_rdata_reg : '0;

    always_comb begin
        state_next        = state_reg;
        item_next         = item_reg;
        load_pos_next     = load_pos_reg;
        emit_pos_next     = emit_pos_reg;
        sorted_len_next   = sorted_len_reg;
        sorted_ready_next = sorted_ready_reg;
        hist_vld_next     = hist_vld_reg;
        k_next            = k_reg;
        acc_next          = acc_reg;
        scan_next         = scan_reg;
        px_next           = px_reg;
        out_valid_next    = (m_valid && m_ready) ? 1'b0 : out_valid_reg;
        out_px_next       = out_px_reg;
        out_end_next      = out_end_reg;
        q_pop             = 1'b0;
        load_we           = 1'b0;
        sort_we           = 1'b0;
        hist_we           = 1'b0;
        load_waddr        = load_pos_reg[AW-1:0];
        load_wdata        = {item_reg.red, item_reg.green, item_reg.blue};
        load_raddr        = scan_reg[AW-1:0];
        sort_raddr        = emit_pos_reg[AW-1:0];
        sort_waddr        = hist_rdata_reg[AW-1:0];
        sort_wdata        = px_reg;
        hist_waddr        = item_reg.red;
        hist_wdata        = CW'(1);
        hist_raddr        = item_reg.red;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && (!out_valid_reg || m_ready)) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = sorted_ready_reg ? ST_EMIT : ST_STORE;
                end
            end
            ST_EMIT: begin
                out_valid_next = 1'b1;
                out_px_next    = sort_rdata_reg;
                out_end_next   = last;
                if (last) begin
                    sorted_ready_next = 1'b0;
                    emit_pos_next     = '0;
                end else begin
                    emit_pos_next = emit_pos_reg + CW'(1);
                end
                state_next = ST_STORE;
            end
            ST_STORE: begin
                if (item_reg.is_pixel) begin
                    load_we = 1'b1;
                    if (load_pos_reg == '0) begin
                        // row start: histogram cleared, this key counts one
                        hist_we                      = 1'b1;
                        hist_vld_next                = '0;
                        hist_vld_next[item_reg.red]  = 1'b1;
                    end
                    state_next = ST_HINC;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_HINC: begin
                if (load_pos_reg != '0) begin
                    hist_we    = 1'b1;
                    hist_wdata = (hist_vld_reg[item_reg.red] ? hist_rdata_reg : '0)
                                 + CW'(1);
                    hist_vld_next[item_reg.red] = 1'b1;
                end
                if (pos_inc >= eff_width) begin
                    sorted_len_next   = pos_inc;
                    sorted_ready_next = 1'b0;
                    load_pos_next     = '0;
                    k_next            = '0;
                    acc_next          = '0;
                    state_next        = ST_PREFIX;
                end else begin
                    load_pos_next = pos_inc;
                    state_next    = ST_IDLE;
                end
            end
            ST_PREFIX: begin
                // read bin k while bin k-1 is turned into its start index
                hist_raddr = k_reg[7:0];
                if (k_reg != 9'd0) begin
                    hist_we                 = 1'b1;
                    hist_waddr              = prev_bin;
                    hist_wdata              = acc_reg;
                    acc_next                = acc_reg + bin_cnt;
                    hist_vld_next[prev_bin] = 1'b1;
                end
                if (k_reg == 9'(NB)) begin
                    scan_next  = '0;
                    state_next = ST_SC_RD;
                end
                k_next = k_reg + 9'd1;
            end
            ST_SC_RD: begin
                if (scan_reg < sorted_len_reg) begin
                    state_next = ST_SC_KEY;
                end else begin
                    emit_pos_next     = '0;
                    sorted_ready_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_SC_KEY: begin
                hist_raddr = load_rdata_reg[23:16];
                px_next    = load_rdata_reg;
                state_next = ST_SC_WR;
            end
            ST_SC_WR: begin
                sort_we    = 1'b1;
                hist_we    = 1'b1;
                hist_waddr = px_reg[23:16];
                hist_wdata = hist_rdata_reg + CW'(1);
                scan_next  = scan_reg + CW'(1);
                state_next = ST_SC_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_we) begin
            load_mem[load_waddr] <= load_wdata;
        end
        load_rdata_reg <= load_mem[load_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sort_we) begin
            sort_mem[sort_waddr] <= sort_wdata;
        end
        sort_rdata_reg <= sort_mem[sort_raddr];
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rdata_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            load_pos_reg     <= '0;
            emit_pos_reg     <= '0;
            sorted_len_reg   <= '0;
            sorted_ready_reg <= 1'b0;
            hist_vld_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            load_pos_reg     <= load_pos_next;
            emit_pos_reg     <= emit_pos_next;
            sorted_len_reg   <= sorted_len_next;
            sorted_ready_reg <= sorted_ready_next;
            hist_vld_reg     <= hist_vld_next;
            out_valid_reg    <= out_valid_next;
        end
        item_reg     <= item_next;
        k_reg        <= k_next;
        acc_reg      <= acc_next;
        scan_reg     <= scan_next;
        px_reg       <= px_next;
        out_px_reg   <= out_px_next;
        out_end_reg  <= out_end_next;
    end

`ifndef SYNTHESIS
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        sorted_ready_reg |-> (sorted_len_reg != '0))
        else $error("sorted row pending with zero length");
    a_emit_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        sorted_ready_reg |-> (emit_pos_reg < sorted_len_reg))
        else $error("emit position beyond sorted row");
    a_bins_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SC_WR) |-> (&hist_vld_reg))
        else $error("scatter with uninitialized start bins");
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !out_valid_reg)
        else $error("emit into occupied output register");
`endif

endmodule

// File: design/pixel_row_sort_by_red.sv
// top level of the row pixel sorter keyed on red
// usage:
//   s_ channel takes one item per transfer: s_pixel_valid high carries a
//   pixel (s_red, s_green, s_blue), low is a drain item that only pulls output.
//   m_ channel gives one pixel of the previous completed row per item, stably
//   sorted by red; m_row_end marks the last pixel of that row. Items that
//   arrive with no sorted row pending give no transfer.
//   cfg_ channel writes row_width (0 acts as 1, above MAX_ROW_WIDTH saturates);
//   write it only while the block is idle. cfg_ready is always high.
// item handling:
//   the sort engine takes each item from the queue, emits a sorted pixel when
//   a sorted row is pending, stores the item and, for a pixel, does the
//   histogram read-modify-write; a two-entry queue in front lets s_ keep
//   transferring meanwhile. The item that completes a row adds a histogram
//   prefix sum and a scatter through the row and histogram memories, each
//   with one write port and one read port.
// reset: aresetn synchronous active low; clears the queue, positions, the
//   pending-row flag and the histogram valid bits; row_width returns to 640.
// stall: when m_ready is low the result waits in the output register and
//   the engine takes no further item; the queue then fills and s_ready drops.
module pixel_row_sort_by_red #(
    parameter int MAX_ROW_WIDTH = prs_pkg::MAX_ROW_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_pixel_valid,
    input  logic [7:0]                s_red,
    input  logic [7:0]                s_green,
    input  logic [7:0]                s_blue,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_red,
    output logic [7:0]                m_out_green,
    output logic [7:0]                m_out_blue,
    output logic                      m_row_end,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [prs_pkg::CFG_W-1:0] cfg_data
);

    logic [prs_pkg::CFG_W-1:0] row_width_reg, row_width_next;
    logic                      q_valid;
    prs_pkg::item_t            q_item;
    logic                      q_pop;

    assign cfg_ready      = 1'b1;
    assign row_width_next = (cfg_valid && cfg_ready) ? cfg_data : row_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= prs_pkg::CFG_W'(prs_pkg::ROW_WIDTH_RESET);
        end else begin
            row_width_reg <= row_width_next;
        end
    end

    prs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_valid (s_pixel_valid),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    prs_back #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .row_width   (row_width_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_row_end   (m_row_end)
    );

endmodule
